// ===== sv/nmd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the message deframer.
// No dependencies; used by netconf_message_deframer.
package nmd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_NL = 4'd1,
        PH_EOM      = 4'd2,
        PH_CH_LF    = 4'd3,
        PH_CH_HASH  = 4'd4,
        PH_CH_FIRST = 4'd5,
        PH_CH_SIZE  = 4'd6,
        PH_CH_DATA  = 4'd7,
        PH_CH_ENDLF = 4'd8,
        PH_CH_OPEN  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
    } result_t;

    localparam int MAX_RESULTS = 6;
    localparam logic [2:0] SEP_LAST = 3'd5;

    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_HASH     = 8'h23;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_ONE      = 8'h31;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_GT       = 8'h3E;
    localparam logic [7:0] CHAR_RBRACKET = 8'h5D;

    localparam logic [2:0] REG_MAX_CHUNK = 3'd0;

    // byte i of the end-of-message separator "]]>]]>"
    function automatic logic [7:0] eom_sep_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd2, 3'd5: r = CHAR_GT;
            default:    r = CHAR_RBRACKET;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/netconf_message_deframer.sv =====
`timescale 1ns / 1ps
// Message deframer: chunked and end-of-message framing, one byte per request.
// Depends on nmd_pkg.
//
// Takes one transport byte per input request (s_tdata) with a link-lost flag
// (s_tuser) and gives payload bytes, message-complete and framing-error
// results on the master side, with m_tlast on the final result of each byte.
// A byte is registered, decoded in one pass against the parse state, and its
// results (up to six) are loaded into a result buffer that drains one per
// cycle while m_tready is high. A byte giving zero or one result frees the
// buffer as that result is taken, so the block sustains one byte per cycle
// when the output does not stall; a byte giving more holds the input until
// the buffer's last result is taken. The input register feeds the buffer.
// max_chunk_size sits at byte address 0 of the APB port and resets to all ones.
module netconf_message_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    input  logic [0:0]  s_tuser,     // [0] link_lost
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] payload_byte
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input register
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_lost_reg;

    // parse state
    nmd_pkg::phase_t     phase_reg, phase_next;
    logic [2:0]          match_reg, match_next;
    logic [31:0]         size_reg, size_next;
    logic [31:0]         max_chunk_reg;

    // result buffer
    nmd_pkg::result_t    list_reg [nmd_pkg::MAX_RESULTS];
    nmd_pkg::result_t    list_next [nmd_pkg::MAX_RESULTS];
    logic [2:0]          cnt_reg, cnt_next;
    logic [2:0]          rd_idx_reg;

    logic                list_free;
    logic                advance;
    logic                out_fire;

    // shared decode
    logic [7:0]          b;
    logic                b_digit;
    logic                b_nz_digit;
    logic [31:0]         acc_base;
    logic [35:0]         acc_sum;
    logic                acc_over;
    logic [31:0]         size_dec;
    logic [2:0]          eff_m;
    logic                eom_is_sep;
    logic [2:0]          eom_keep;
    logic [2:0]          eom_emit;
    logic [7:0]          pre_bytes [nmd_pkg::MAX_RESULTS + 1];

    // ------------------------------------------------------------------
    // handshake and configuration
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == nmd_pkg::REG_MAX_CHUNK[0]) ? max_chunk_reg : 32'd0;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (rd_idx_reg == cnt_reg - 3'd1);
    assign m_tdata  = list_reg[rd_idx_reg].data;
    assign m_tuser  = list_reg[rd_idx_reg].kind;
    assign out_fire = m_tvalid && m_tready;

    assign list_free = (cnt_reg == 3'd0) || (out_fire && m_tlast);
    assign advance   = in_valid_reg && list_free;
    assign s_tready  = !in_valid_reg || list_free;

    // ------------------------------------------------------------------
    // shared decode of the registered byte
    // ------------------------------------------------------------------
    assign b          = in_byte_reg;
    assign b_digit    = (b >= nmd_pkg::CHAR_ZERO) && (b <= nmd_pkg::CHAR_NINE);
    assign b_nz_digit = (b >= nmd_pkg::CHAR_ONE) && (b <= nmd_pkg::CHAR_NINE);

    // size accumulation: acc * 10 + digit
    assign acc_base = (phase_reg == nmd_pkg::PH_CH_SIZE) ? size_reg : 32'd0;
    assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                    + {32'd0, b[3:0]};
    assign acc_over = acc_sum > {4'd0, max_chunk_reg};
    assign size_dec = (size_reg != 32'd0) ? size_reg - 32'd1 : size_reg;

    // separator bytes held so far; zero when starting a message
    always_comb begin
        if (phase_reg == nmd_pkg::PH_EOM) begin
            eff_m = (match_reg > nmd_pkg::SEP_LAST) ? nmd_pkg::SEP_LAST : match_reg;
        end else begin
            eff_m = 3'd0;
        end
    end

    // on a mismatch the only overlap left is "]]" when the byte is ']'
    assign eom_is_sep = (b == nmd_pkg::eom_sep_byte(eff_m));
    assign eom_keep   = (b == nmd_pkg::CHAR_RBRACKET) ? 3'd2 : 3'd0;
    assign eom_emit   = eom_is_sep ? 3'd0 : eff_m + 3'd1 - eom_keep;

    // released bytes, with a leading newline slot in front
    always_comb begin
        pre_bytes[0] = nmd_pkg::CHAR_LF;
        for (int i = 0; i < nmd_pkg::MAX_RESULTS; i++) begin
            pre_bytes[i + 1] = (3'(i) < eff_m) ? nmd_pkg::eom_sep_byte(3'(i)) : b;
        end
    end

    // ------------------------------------------------------------------
    // next parse state
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        size_next  = size_reg;
        if (in_lost_reg) begin
            phase_next = nmd_pkg::PH_IDLE;
            match_next = 3'd0;
            size_next  = 32'd0;
        end else begin
            unique case (phase_reg)
                nmd_pkg::PH_START_NL, nmd_pkg::PH_EOM: begin
                    if (phase_reg == nmd_pkg::PH_START_NL && b == nmd_pkg::CHAR_HASH) begin
                        phase_next = nmd_pkg::PH_CH_OPEN;
                    end else if (eom_is_sep && eff_m == nmd_pkg::SEP_LAST) begin
                        phase_next = nmd_pkg::PH_IDLE;
                        match_next = 3'd0;
                        size_next  = 32'd0;
                    end else begin
                        phase_next = nmd_pkg::PH_EOM;
                        match_next = eom_is_sep ? eff_m + 3'd1 : eom_keep;
                    end
                end
                nmd_pkg::PH_CH_LF: begin
                    phase_next = (b == nmd_pkg::CHAR_LF) ? nmd_pkg::PH_CH_HASH
                                                         : nmd_pkg::PH_IDLE;
                    size_next  = (b == nmd_pkg::CHAR_LF) ? size_reg : 32'd0;
                    match_next = 3'd0;
                end
                nmd_pkg::PH_CH_HASH: begin
                    phase_next = (b == nmd_pkg::CHAR_HASH) ? nmd_pkg::PH_CH_FIRST
                                                           : nmd_pkg::PH_IDLE;
                    size_next  = (b == nmd_pkg::CHAR_HASH) ? size_reg : 32'd0;
                    match_next = 3'd0;
                end
                nmd_pkg::PH_CH_OPEN, nmd_pkg::PH_CH_FIRST, nmd_pkg::PH_CH_SIZE: begin
                    if ((phase_reg == nmd_pkg::PH_CH_SIZE) ? b_digit : b_nz_digit) begin
                        if (acc_over) begin
                            phase_next = nmd_pkg::PH_IDLE;
                            match_next = 3'd0;
                            size_next  = 32'd0;
                        end else begin
                            phase_next = nmd_pkg::PH_CH_SIZE;
                            size_next  = acc_sum[31:0];
                        end
                    end else if (phase_reg == nmd_pkg::PH_CH_FIRST
                                 && b == nmd_pkg::CHAR_HASH) begin
                        phase_next = nmd_pkg::PH_CH_ENDLF;
                    end else if (phase_reg == nmd_pkg::PH_CH_SIZE
                                 && b == nmd_pkg::CHAR_LF && size_reg != 32'd0) begin
                        phase_next = nmd_pkg::PH_CH_DATA;
                    end else begin
                        phase_next = nmd_pkg::PH_IDLE;
                        match_next = 3'd0;
                        size_next  = 32'd0;
                    end
                end
                nmd_pkg::PH_CH_DATA: begin
                    size_next = size_dec;
                    if (size_dec == 32'd0) begin
                        phase_next = nmd_pkg::PH_CH_LF;
                    end
                end
                nmd_pkg::PH_CH_ENDLF: begin
                    phase_next = nmd_pkg::PH_IDLE;
                    match_next = 3'd0;
                    size_next  = 32'd0;
                end
                default: begin
                    size_next = 32'd0;
                    if (b == nmd_pkg::CHAR_LF) begin
                        phase_next = nmd_pkg::PH_START_NL;
                        match_next = 3'd0;
                    end else begin
                        phase_next = nmd_pkg::PH_EOM;
                        match_next = eom_is_sep ? 3'd1 : eom_keep;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // results of the registered byte
    // ------------------------------------------------------------------
    always_comb begin
        logic eom_path;
        logic lead;
        eom_path = 1'b0;
        lead     = 1'b0;
        cnt_next = 3'd0;
        for (int j = 0; j < nmd_pkg::MAX_RESULTS; j++) begin
            list_next[j].kind = nmd_pkg::KIND_DATA;
            list_next[j].data = 8'd0;
        end
        if (in_lost_reg) begin
            if (phase_reg != nmd_pkg::PH_IDLE) begin
                list_next[0].kind = nmd_pkg::KIND_ERROR;
                cnt_next          = 3'd1;
            end
        end else begin
            unique case (phase_reg)
                nmd_pkg::PH_START_NL: begin
                    if (b != nmd_pkg::CHAR_HASH) begin
                        eom_path = 1'b1;
                        lead     = 1'b1;
                    end
                end
                nmd_pkg::PH_EOM: begin
                    eom_path = 1'b1;
                end
                nmd_pkg::PH_CH_LF: begin
                    if (b != nmd_pkg::CHAR_LF) begin
                        list_next[0].kind = nmd_pkg::KIND_ERROR;
                        cnt_next          = 3'd1;
                    end
                end
                nmd_pkg::PH_CH_HASH: begin
                    if (b != nmd_pkg::CHAR_HASH) begin
                        list_next[0].kind = nmd_pkg::KIND_ERROR;
                        cnt_next          = 3'd1;
                    end
                end
                nmd_pkg::PH_CH_OPEN, nmd_pkg::PH_CH_FIRST, nmd_pkg::PH_CH_SIZE: begin
                    if ((phase_reg == nmd_pkg::PH_CH_SIZE) ? b_digit : b_nz_digit) begin
                        if (acc_over) begin
                            list_next[0].kind = nmd_pkg::KIND_ERROR;
                            cnt_next          = 3'd1;
                        end
                    end else if (!(phase_reg == nmd_pkg::PH_CH_FIRST
                                   && b == nmd_pkg::CHAR_HASH)
                                 && !(phase_reg == nmd_pkg::PH_CH_SIZE
                                      && b == nmd_pkg::CHAR_LF && size_reg != 32'd0)) begin
                        list_next[0].kind = nmd_pkg::KIND_ERROR;
                        cnt_next          = 3'd1;
                    end
                end
                nmd_pkg::PH_CH_DATA: begin
                    list_next[0].data = b;
                    cnt_next          = 3'd1;
                end
                nmd_pkg::PH_CH_ENDLF: begin
                    list_next[0].kind = (b == nmd_pkg::CHAR_LF) ? nmd_pkg::KIND_DONE
                                                                : nmd_pkg::KIND_ERROR;
                    cnt_next          = 3'd1;
                end
                default: begin
                    if (b != nmd_pkg::CHAR_LF) begin
                        eom_path = 1'b1;
                    end
                end
            endcase

            if (eom_path) begin
                if (eom_is_sep && eff_m == nmd_pkg::SEP_LAST) begin
                    list_next[0].kind = nmd_pkg::KIND_DONE;
                    cnt_next          = 3'd1;
                end else begin
                    // a leading newline only occurs with nothing held back
                    for (int j = 0; j < nmd_pkg::MAX_RESULTS; j++) begin
                        list_next[j].data = lead ? pre_bytes[j] : pre_bytes[j + 1];
                    end
                    cnt_next = eom_emit + {2'b00, lead};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= nmd_pkg::PH_IDLE;
            match_reg     <= 3'd0;
            size_reg      <= 32'd0;
            max_chunk_reg <= 32'hFFFF_FFFF;
            cnt_reg       <= 3'd0;
            rd_idx_reg    <= 3'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (psel && penable && pwrite && pready
                && paddr[2] == nmd_pkg::REG_MAX_CHUNK[0]) begin
                max_chunk_reg <= pwdata;
            end

            if (advance) begin
                phase_reg  <= phase_next;
                match_reg  <= match_next;
                size_reg   <= size_next;
                cnt_reg    <= cnt_next;
                rd_idx_reg <= 3'd0;
            end else if (out_fire) begin
                if (m_tlast) begin
                    cnt_reg    <= 3'd0;
                    rd_idx_reg <= 3'd0;
                end else begin
                    rd_idx_reg <= rd_idx_reg + 3'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_lost_reg <= s_tuser[0];
        end
        if (advance) begin
            for (int j = 0; j < nmd_pkg::MAX_RESULTS; j++) begin
                list_reg[j] <= list_next[j];
            end
        end
    end

endmodule
